FILE: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared codes for the double-ended queue
// Holds the operation codes carried on func and the status codes that
// are returned with every result item.
// ----------------------------------------------------------------------------
package dq_pkg;

	// Operation codes on the func input.
	typedef enum logic [1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_BACK  = 2'd1,
		FN_POP_FRONT  = 2'd2,
		FN_POP_BACK   = 2'd3
	} func_t;

	// Status codes on the status output.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Fixed widths of the item fields.
	localparam int unsigned DATA_W = 64;
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned STAT_W = 2;

endpackage

FILE: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque held in a circular-buffer memory
// Push or pop at either end, one item per clock while busy is low, with status and occupancy.
// ----------------------------------------------------------------------------
// Usage:
// An item (func, entry_data) is taken at a rising edge where start is high
// and busy is low. Each item gives exactly one result item, shown on
// popped_data, status and occupancy while done is high, for one cycle, in the
// cycle right after the item was taken. The receiver cannot stall, so results
// are never held back.
// The block takes a new item every cycle while busy is low: the entries
// live in one single-port synchronous memory and each item makes at most one
// access to it (a write for an accepted push, a read for a successful pop) at
// its accept edge. Rejected pushes and pops on an empty queue touch nothing.
// Pointer and count updates happen at that same edge, so back-to-back items
// always see the memory and pointers left by the previous one.
// A push while full returns the full status and changes nothing; a pop while
// empty returns zero data and the empty status.
// Reset clears the front index and the count; memory contents stay as they
// are and are never read before being written. busy is high during reset and
// in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int unsigned DEPTH       = 64,
	parameter int unsigned ENTRY_WIDTH = 64,
	localparam int unsigned CW         = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [dq_pkg::FUNC_W-1:0]  func,
	input  logic [dq_pkg::DATA_W-1:0]  entry_data,
	output logic                       done,
	output logic [dq_pkg::DATA_W-1:0]  popped_data,
	output logic [dq_pkg::STAT_W-1:0]  status,
	output logic [CW-1:0]              occupancy
);
	import dq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [CW:0] DEPTH_X = (CW + 1)'(DEPTH);

	// Pointer state.
	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          busy_q;

	// Result stage.
	logic                   done_s1;
	logic                   pop_ok_s1;
	logic [STAT_W-1:0]      status_s1;
	logic [CW-1:0]          occ_s1;
	logic [ENTRY_WIDTH-1:0] rd_s1;

	// Entry memory.
	logic [ENTRY_WIDTH-1:0] mem [DEPTH];

	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic [CW:0]   off;
	logic [CW:0]   sum;
	logic [AW-1:0] slot;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW-1:0] addr;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] front_nxt;
	logic [CW-1:0] count_nxt;
	logic [STAT_W-1:0] status_nxt;

	assign accept   = start && !busy_q;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// Slot a given distance behind the front, wrapped once around the buffer, and the front index stepped down and up.
	always_comb begin
		off = (func == FN_POP_BACK) ? {1'b0, count_q} - 1'b1 : {1'b0, count_q};
		sum = (CW + 1)'(front_q) + off;
		if (sum >= DEPTH_X) begin
			slot = AW'(sum - DEPTH_X);
		end else begin
			slot = AW'(sum);
		end
		front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
		front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	end

	// Decode the operation into at most one memory access, the status and the next pointers.
	always_comb begin
		addr       = slot;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		case (func_t'(func))
			FN_PUSH_FRONT: begin
				if (is_full) begin
					status_nxt = ST_FULL;
				end else begin
					addr      = front_dec;
					wr_en     = 1'b1;
					front_nxt = front_dec;
					count_nxt = count_q + 1'b1;
				end
			end
			FN_PUSH_BACK: begin
				if (is_full) begin
					status_nxt = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					addr      = front_q;
					rd_en     = 1'b1;
					front_nxt = front_inc;
					count_nxt = count_q - 1'b1;
				end
			end
			FN_POP_BACK: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					rd_en     = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	// Memory port: at most one write or one registered read per accepted item.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem[addr] <= entry_data[ENTRY_WIDTH-1:0];
		end
		if (accept && rd_en) begin
			rd_s1 <= mem[addr];
		end
	end

	// Pointer and handshake control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			busy_q  <= 1'b1;
			done_s1 <= 1'b0;
		end else begin
			busy_q  <= 1'b0;
			done_s1 <= accept;
			if (accept) begin
				front_q <= front_nxt;
				count_q <= count_nxt;
			end
		end
	end

	// Result fields travel alongside the memory read.
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1 <= rd_en;
			status_s1 <= status_nxt;
			occ_s1    <= count_nxt;
		end
	end

	assign busy        = busy_q;
	assign done        = done_s1;
	assign status      = status_s1;
	assign occupancy   = occ_s1;
	assign popped_data = pop_ok_s1 ? DATA_W'(rd_s1) : '0;

	// The count never goes past the buffer size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	// Every accepted item gives exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without an accepted item");

	// A full status is only reported with the queue at capacity.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> occupancy == CW'(DEPTH))
		else $error("full status with queue not at capacity");

	// A successful pop lowers the count by one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rd_en) |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("pop did not decrement the count");

endmodule
